// ===== hdl/fpsv_pkg.sv =====
// Shared types, constants and tables of the five-phase space vector PWM.
// Used by the controller, the datapath and the top level.
package fpsv_pkg;

  localparam int TIME_WIDTH = 16;
  localparam logic [15:0] PERIOD_MASK = 16'((33'h1 << TIME_WIDTH) - 33'h1);
  localparam logic [15:0] PERIOD_RESET = 16'd1000 & PERIOD_MASK;

  localparam int ITER_STEPS = 16;
  localparam int CORDIC_STEPS = 14;
  localparam int DIV_STEPS = TIME_WIDTH;
  localparam int MAX_STEPS = (DIV_STEPS > ITER_STEPS) ? DIV_STEPS : ITER_STEPS;
  localparam int ITER_W = $clog2(MAX_STEPS);

  localparam int GAIN_Q14 = 9113;
  localparam int CORDIC_START = 9949;
  localparam int ROUND_HALF = 8192;

  localparam int PC_W = 6;
  localparam int START_ENTRY = 0;
  localparam int OUT_ENTRY = 25;

  typedef enum logic {
    REG_PERIOD_TICKS = 1'b0,
    REG_VECTOR_SET   = 1'b1
  } reg_index_t;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  typedef enum logic [2:0] {
    U_NOP,
    U_ITER,
    U_DIV,
    U_FINAL,
    U_BITS,
    U_END
  } uop_t;

  typedef enum logic [3:0] {
    M_NONE,
    M_RC,
    M_RS,
    M_X1Y2,
    M_X2Y1,
    M_USX_Y2,
    M_USY_X2,
    M_USY_X1,
    M_USX_Y1,
    M_NLO,
    M_NHI,
    M_DC0,
    M_DC1,
    M_DC2,
    M_DC3
  } mul_t;

  typedef enum logic [1:0] {
    A_NONE,
    A_LOAD,
    A_SUB,
    A_ADDSH
  } acc_t;

  typedef enum logic [3:0] {
    W_NONE,
    W_USX,
    W_USY,
    W_DET,
    W_NUM,
    W_N,
    W_T1,
    W_T2,
    W_OUT0,
    W_OUT1,
    W_OUT2,
    W_OUT3
  } wb_t;

  typedef struct packed {
    uop_t op;
    mul_t mul;
    acc_t acc;
    wb_t  wb;
  } uword_t;

  typedef struct packed {
    logic              load;
    logic              commit;
    uword_t            word;
    logic [ITER_W-1:0] iter;
  } cmd_t;

  typedef struct packed {
    logic start;
  } status_t;

  localparam uword_t UW_NOP = '{op: U_NOP, mul: M_NONE, acc: A_NONE, wb: W_NONE};

  function automatic uword_t uw(uop_t op, mul_t mul, acc_t acc, wb_t wb);
    uword_t w;
    w.op = op;
    w.mul = mul;
    w.acc = acc;
    w.wb = wb;
    return w;
  endfunction

  // Sequencer program. A multiply's product and accumulate mode are registered before the accumulator takes them.
  function automatic uword_t ucode(int unsigned addr);
    uword_t w;
    w = UW_NOP;
    case (addr)
      0:  w = uw(U_ITER, M_NONE,   A_NONE,  W_NONE);
      1:  w = uw(U_NOP,  M_RC,     A_LOAD,  W_NONE);
      2:  w = uw(U_NOP,  M_RS,     A_LOAD,  W_NONE);
      3:  w = uw(U_NOP,  M_X1Y2,   A_LOAD,  W_USX);
      4:  w = uw(U_NOP,  M_X2Y1,   A_SUB,   W_USY);
      5:  w = uw(U_NOP,  M_USX_Y2, A_LOAD,  W_NONE);
      6:  w = uw(U_NOP,  M_USY_X2, A_SUB,   W_DET);
      7:  w = uw(U_NOP,  M_NONE,   A_NONE,  W_NONE);
      8:  w = uw(U_NOP,  M_NONE,   A_NONE,  W_NUM);
      9:  w = uw(U_NOP,  M_NLO,    A_LOAD,  W_NONE);
      10: w = uw(U_NOP,  M_NHI,    A_ADDSH, W_NONE);
      11: w = uw(U_NOP,  M_NONE,   A_NONE,  W_NONE);
      12: w = uw(U_NOP,  M_NONE,   A_NONE,  W_N);
      13: w = uw(U_DIV,  M_NONE,   A_NONE,  W_NONE);
      14: w = uw(U_NOP,  M_USY_X1, A_LOAD,  W_T1);
      15: w = uw(U_NOP,  M_USX_Y1, A_SUB,   W_NONE);
      16: w = uw(U_NOP,  M_NONE,   A_NONE,  W_NONE);
      17: w = uw(U_NOP,  M_NONE,   A_NONE,  W_NUM);
      18: w = uw(U_NOP,  M_NLO,    A_LOAD,  W_NONE);
      19: w = uw(U_NOP,  M_NHI,    A_ADDSH, W_NONE);
      20: w = uw(U_NOP,  M_NONE,   A_NONE,  W_NONE);
      21: w = uw(U_NOP,  M_NONE,   A_NONE,  W_N);
      22: w = uw(U_DIV,  M_NONE,   A_NONE,  W_NONE);
      23: w = uw(U_NOP,  M_NONE,   A_NONE,  W_T2);
      24: w = uw(U_FINAL, M_NONE,  A_NONE,  W_NONE);
      25: w = uw(U_BITS, M_NONE,   A_NONE,  W_NONE);
      26: w = uw(U_NOP,  M_DC0,    A_LOAD,  W_NONE);
      27: w = uw(U_NOP,  M_DC1,    A_LOAD,  W_NONE);
      28: w = uw(U_NOP,  M_DC2,    A_LOAD,  W_OUT0);
      29: w = uw(U_NOP,  M_DC3,    A_LOAD,  W_OUT1);
      30: w = uw(U_NOP,  M_NONE,   A_NONE,  W_OUT2);
      31: w = uw(U_NOP,  M_NONE,   A_NONE,  W_OUT3);
      32: w = uw(U_END,  M_NONE,   A_NONE,  W_NONE);
      default: w = UW_NOP;
    endcase
    return w;
  endfunction

  function automatic logic signed [17:0] step_angle(logic [ITER_W-1:0] i);
    logic signed [17:0] r;
    case (int'(i))
      0:  r = 18'sd8192;
      1:  r = 18'sd4836;
      2:  r = 18'sd2555;
      3:  r = 18'sd1297;
      4:  r = 18'sd651;
      5:  r = 18'sd326;
      6:  r = 18'sd163;
      7:  r = 18'sd81;
      8:  r = 18'sd41;
      9:  r = 18'sd20;
      10: r = 18'sd10;
      11: r = 18'sd5;
      12: r = 18'sd3;
      13: r = 18'sd1;
      default: r = 18'sd0;
    endcase
    return r;
  endfunction

  // Base vector of the normal and fault rows, used for the fault fallback.
  function automatic logic [4:0] vec_row(logic row, logic [3:0] sec);
    logic [4:0] r;
    case (sec)
      4'd0: r = row ? 5'h00 : 5'h10;
      4'd1: r = row ? 5'h08 : 5'h18;
      4'd2: r = 5'h08;
      4'd3: r = 5'h0C;
      4'd4: r = 5'h04;
      4'd5: r = 5'h06;
      4'd6: r = 5'h02;
      4'd7: r = 5'h03;
      4'd8: r = 5'h01;
      default: r = row ? 5'h01 : 5'h11;
    endcase
    return r;
  endfunction

  // First vector: nearest usable entry at or before the sector.
  function automatic logic [4:0] pick_first(logic [1:0] row, logic [3:0] sec);
    logic [4:0] r;
    case (sec)
      4'd0: r = (row == 2'd0) ? 5'h10 : (row == 2'd1) ? 5'h00 :
                (row == 2'd2) ? 5'h09 : 5'h01;
      4'd1: r = (row == 2'd0) ? 5'h18 : (row == 2'd1) ? 5'h08 :
                (row == 2'd2) ? 5'h09 : 5'h01;
      4'd2: r = 5'h08;
      4'd3: r = 5'h0C;
      4'd4: r = 5'h04;
      4'd5: r = 5'h06;
      4'd6: r = 5'h02;
      4'd7: r = 5'h03;
      4'd8: r = 5'h01;
      default: r = (row == 2'd0) ? 5'h11 : 5'h01;
    endcase
    return r;
  endfunction

  // Second vector: nearest usable entry after the sector.
  function automatic logic [4:0] pick_second(logic [1:0] row, logic [3:0] sec);
    logic [4:0] r;
    case (sec)
      4'd0: r = (row == 2'd0) ? 5'h18 : 5'h08;
      4'd1: r = 5'h08;
      4'd2: r = 5'h0C;
      4'd3: r = 5'h04;
      4'd4: r = 5'h06;
      4'd5: r = 5'h02;
      4'd6: r = 5'h03;
      4'd7: r = 5'h01;
      4'd8: r = (row == 2'd0) ? 5'h11 : (row == 2'd1) ? 5'h01 :
                (row == 2'd2) ? 5'h09 : 5'h08;
      default: r = (row == 2'd0) ? 5'h10 : (row == 2'd1) ? 5'h00 :
                   (row == 2'd2) ? 5'h09 : 5'h08;
    endcase
    return r;
  endfunction

  // Plane 0 alpha first, 1 beta first, 2 alpha third, 3 beta third; Q2.14.
  function automatic logic signed [16:0] projection(logic [1:0] plane, logic [4:0] bits);
    int a;
    int b;
    int c;
    int d;
    int e;
    int r;
    a = bits[4] ? 1 : -1;
    b = bits[3] ? 1 : -1;
    c = bits[2] ? 1 : -1;
    d = bits[1] ? 1 : -1;
    e = bits[0] ? 1 : -1;
    case (plane)
      2'd0: r = 8192 * a + 2531 * (b + e) - 6627 * (c + d);
      2'd1: r = 7791 * (b - e) + 4815 * (c - d);
      2'd2: r = 8192 * a - 6627 * (b + e) + 2531 * (c + d);
      default: r = 4815 * (b - e) - 7791 * (c - d);
    endcase
    return 17'(r);
  endfunction

endpackage

// ===== hdl/fpsv_ctrl.sv =====
// Controller of the five-phase space vector PWM: handshake, program counter
// and step counter of the sequencer. Depends on fpsv_pkg.
module fpsv_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  fpsv_pkg::status_t status,
  output fpsv_pkg::cmd_t    cmd
);
  import fpsv_pkg::*;

  state_t            state, state_next;
  logic [PC_W-1:0]   pc, pc_next;
  logic [ITER_W-1:0] iter, iter_next;
  logic              out_valid_next;
  uword_t            word;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc <= '0;
      iter <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pc <= pc_next;
      iter <= iter_next;
      out_valid <= out_valid_next;
    end
  end

  assign word = ucode(int'(pc));

  always_comb begin
    state_next = state;
    pc_next = pc;
    iter_next = iter;
    in_ready = 1'b0;
    cmd.load = 1'b0;
    cmd.commit = 1'b0;
    cmd.word = UW_NOP;
    cmd.iter = iter;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          pc_next = status.start ? PC_W'(START_ENTRY) : PC_W'(OUT_ENTRY);
          iter_next = '0;
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        cmd.word = word;
        unique case (word.op)
          U_ITER: begin
            if (iter == ITER_W'(ITER_STEPS - 1)) begin
              iter_next = '0;
              pc_next = pc + 1'b1;
            end else begin
              iter_next = iter + 1'b1;
            end
          end
          U_DIV: begin
            if (iter == ITER_W'(DIV_STEPS - 1)) begin
              iter_next = '0;
              pc_next = pc + 1'b1;
            end else begin
              iter_next = iter + 1'b1;
            end
          end
          U_END: begin
            // The result register must be free or emptying this cycle.
            if (!out_valid || out_ready) begin
              cmd.commit = 1'b1;
              state_next = S_IDLE;
            end
          end
          default: pc_next = pc + 1'b1;
        endcase
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

// ===== hdl/fpsv_dp.sv =====
// Datapath of the five-phase space vector PWM: ratio divider, CORDIC,
// shared multiply-accumulate, on-time divider, tick counter and result words.
// Depends on fpsv_pkg.
module fpsv_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic [15:0]         amplitude,
  input  logic [15:0]         angle,
  input  logic [15:0]         dc_voltage,
  input  logic                phase_a_current_negative,
  input  fpsv_pkg::cmd_t      cmd,
  output fpsv_pkg::status_t   status,
  output logic signed [17:0]  alpha_first,
  output logic signed [17:0]  beta_first,
  output logic signed [17:0]  alpha_third,
  output logic signed [17:0]  beta_third,
  output logic [4:0]          switch_bits,
  output logic                period_start
);
  import fpsv_pkg::*;

  typedef enum logic [1:0] {
    T_ZERO,
    T_PERIOD,
    T_DIVIDE
  } solve_t;

  // Configuration and tick state.
  logic [15:0]  period;
  logic [1:0]   vector_set;
  logic [16:0]  tick_counter;
  logic         count_direction;
  logic [16:0]  on_time [5];

  // Item registers.
  logic [15:0]  dc_r;
  logic [1:0]   amp_lo;
  logic         start_r;
  logic [4:0]   v1, v2;

  // Ratio divider.
  logic [15:0]  rq;
  logic [15:0]  rrem;
  logic         rsat;
  logic [16:0]  rtry;
  logic         rbit;
  logic [15:0]  ratio;

  // CORDIC.
  logic signed [17:0] cx, cy, cz;
  logic               cflip;
  logic signed [17:0] cs, sn;
  logic [15:0]        ang_q, ang_h;
  logic               flip_in;

  // Multiply-accumulate.
  logic signed [20:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [38:0] prod;
  acc_t               acc_mode;
  logic signed [49:0] acc;
  logic signed [20:0] usx, usy;
  logic signed [33:0] det;
  logic signed [35:0] num;
  logic [34:0]        mag;
  logic [32:0]        det_mag;
  logic signed [16:0] x1, y1, x2, y2;

  // On-time divider.
  logic [49:0]           db, dcd, drem, dsum, dtwo;
  logic [TIME_WIDTH-1:0] dres, pshift, period_tw;
  solve_t                smode;
  logic [15:0]           tval;
  logic [15:0]           t1, t2;

  // Results.
  logic [4:0]         bits_now, bits_r;
  logic signed [17:0] res [4];
  logic signed [17:0] rounded;

  // Sector and row selection.
  logic [19:0] sec_mul;
  logic [3:0]  sec;
  logic [1:0]  row;

  assign status.start = (tick_counter == '0);
  assign period_tw = TIME_WIDTH'(period);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      period <= PERIOD_RESET;
      vector_set <= 2'd0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_PERIOD_TICKS: period <= cfg_data & PERIOD_MASK;
        REG_VECTOR_SET:   vector_set <= cfg_data[1:0];
      endcase
    end
  end

  // Sector of a tenth of a turn and the row that picks the two adjacent vectors.
  always_comb begin
    sec_mul = {1'b0, angle, 3'b000} + {3'b000, angle, 1'b0};
    sec = sec_mul[19:16];
    row = vector_set;
    if (vector_set == 2'd1 && phase_a_current_negative &&
        vec_row(1'b0, sec) != vec_row(1'b1, sec)) begin
      row = 2'd0;
    end
  end

  // The CORDIC works in the right half plane; the left half is mirrored.
  assign ang_q = angle + 16'h4000;
  assign flip_in = ang_q[15];
  assign ang_h = flip_in ? angle + 16'h8000 : angle;

  assign ratio = rsat ? 16'hFFFF : rq;
  assign rbit = (cmd.iter == ITER_W'(0)) ? amp_lo[1] :
                (cmd.iter == ITER_W'(1)) ? amp_lo[0] : 1'b0;
  assign rtry = {rrem, rbit};
  assign cs = cflip ? -cx : cx;
  assign sn = cflip ? -cy : cy;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dc_r <= dc_voltage;
      amp_lo <= amplitude[1:0];
      start_r <= status.start;
      v1 <= pick_first(row, sec);
      v2 <= pick_second(row, sec);
      rq <= '0;
      rrem <= {2'b00, amplitude[15:2]};
      rsat <= (dc_voltage == '0) || ({2'b00, amplitude} >= {dc_voltage, 2'b00});
      cx <= 18'(CORDIC_START);
      cy <= '0;
      cz <= 18'(signed'(ang_h));
      cflip <= flip_in;
    end else if (cmd.word.op == U_ITER) begin
      if (rtry >= {1'b0, dc_r}) begin
        rrem <= 16'(rtry - {1'b0, dc_r});
        rq <= {rq[14:0], 1'b1};
      end else begin
        rrem <= rtry[15:0];
        rq <= {rq[14:0], 1'b0};
      end
      if (cmd.iter < ITER_W'(CORDIC_STEPS)) begin
        if (!cz[17]) begin
          cx <= cx - (cy >>> cmd.iter);
          cy <= cy + (cx >>> cmd.iter);
          cz <= cz - step_angle(cmd.iter);
        end else begin
          cx <= cx + (cy >>> cmd.iter);
          cy <= cy - (cx >>> cmd.iter);
          cz <= cz + step_angle(cmd.iter);
        end
      end
    end
  end

  assign x1 = projection(2'd0, v1);
  assign y1 = projection(2'd1, v1);
  assign x2 = projection(2'd0, v2);
  assign y2 = projection(2'd1, v2);
  assign mag = 35'(num[35] ? -num : num);
  assign det_mag = 33'(det[33] ? -det : det);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.word.mul)
      M_RC:     begin mul_a = 21'({1'b0, ratio}); mul_b = cs; end
      M_RS:     begin mul_a = 21'({1'b0, ratio}); mul_b = sn; end
      M_X1Y2:   begin mul_a = 21'(x1); mul_b = 18'(y2); end
      M_X2Y1:   begin mul_a = 21'(x2); mul_b = 18'(y1); end
      M_USX_Y2: begin mul_a = usx; mul_b = 18'(y2); end
      M_USY_X2: begin mul_a = usy; mul_b = 18'(x2); end
      M_USY_X1: begin mul_a = usy; mul_b = 18'(x1); end
      M_USX_Y1: begin mul_a = usx; mul_b = 18'(y1); end
      M_NLO:    begin mul_a = 21'({1'b0, mag[16:0]}); mul_b = 18'(GAIN_Q14); end
      M_NHI:    begin mul_a = 21'({1'b0, mag[34:17]}); mul_b = 18'(GAIN_Q14); end
      M_DC0:    begin mul_a = 21'({1'b0, dc_r}); mul_b = 18'(projection(2'd0, bits_r)); end
      M_DC1:    begin mul_a = 21'({1'b0, dc_r}); mul_b = 18'(projection(2'd1, bits_r)); end
      M_DC2:    begin mul_a = 21'({1'b0, dc_r}); mul_b = 18'(projection(2'd2, bits_r)); end
      M_DC3:    begin mul_a = 21'({1'b0, dc_r}); mul_b = 18'(projection(2'd3, bits_r)); end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // The product is registered; it is accumulated in the next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_mode <= A_NONE;
    end else begin
      acc_mode <= cmd.word.acc;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (acc_mode)
      A_LOAD:  acc <= 50'(prod);
      A_SUB:   acc <= acc - 50'(prod);
      A_ADDSH: acc <= acc + (50'(prod) <<< 17);
      default: acc <= acc;
    endcase
  end

  // On-time divider step: up to two subtractions of the divisor per bit.
  assign dtwo = {dcd[48:0], 1'b0};
  assign dsum = {drem[48:0], 1'b0} + (pshift[TIME_WIDTH-1] ? db : '0);
  assign rounded = 18'((acc + 50'(ROUND_HALF)) >>> 14);

  always_comb begin
    unique case (smode)
      T_PERIOD: tval = period;
      T_DIVIDE: tval = 16'(dres);
      default:  tval = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    case (cmd.word.wb)
      W_USX:  usx <= 21'(acc >>> 14);
      W_USY:  usy <= 21'(acc >>> 14);
      W_DET:  det <= 34'(acc);
      W_NUM:  num <= 36'(acc);
      W_N: begin
        db <= acc;
        dcd <= {3'b000, det_mag, 14'b0};
        drem <= '0;
        dres <= '0;
        pshift <= period_tw;
        if (det == '0) begin
          smode <= (!num[35] && num != '0) ? T_PERIOD : T_ZERO;
        end else if (num == '0 || num[35] != det[33]) begin
          smode <= T_ZERO;
        end else if (acc >= signed'({3'b000, det_mag, 14'b0})) begin
          smode <= T_PERIOD;
        end else begin
          smode <= T_DIVIDE;
        end
      end
      W_T1:   t1 <= tval;
      W_T2:   t2 <= tval;
      W_OUT0: res[0] <= rounded;
      W_OUT1: res[1] <= rounded;
      W_OUT2: res[2] <= rounded;
      W_OUT3: res[3] <= rounded;
      default: ;
    endcase
    if (cmd.word.op == U_DIV) begin
      pshift <= {pshift[TIME_WIDTH-2:0], 1'b0};
      if (dsum >= dtwo) begin
        drem <= dsum - dtwo;
        dres <= {dres[TIME_WIDTH-2:0], 1'b0} + TIME_WIDTH'(2);
      end else if (dsum >= dcd) begin
        drem <= dsum - dcd;
        dres <= {dres[TIME_WIDTH-2:0], 1'b1};
      end else begin
        drem <= dsum;
        dres <= {dres[TIME_WIDTH-2:0], 1'b0};
      end
    end
    if (cmd.word.op == U_BITS) begin
      bits_r <= bits_now;
    end
  end

  // Carrier compare of each phase against its on-time.
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      if (count_direction) begin
        bits_now[i] = (on_time[i] != '0) &&
                      (({1'b0, tick_counter} + {1'b0, on_time[i]}) > {2'b00, period});
      end else begin
        bits_now[i] = tick_counter < on_time[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_counter <= '0;
      count_direction <= 1'b1;
      for (int i = 0; i < 5; i++) begin
        on_time[i] <= '0;
      end
    end else begin
      if (cmd.word.op == U_FINAL) begin
        count_direction <= ~count_direction;
        for (int i = 0; i < 5; i++) begin
          on_time[i] <= (v1[i] ? {1'b0, t1} : 17'd0) + (v2[i] ? {1'b0, t2} : 17'd0);
        end
      end
      if (cmd.commit) begin
        if (tick_counter > {1'b0, period}) begin
          tick_counter <= '0;
        end else begin
          tick_counter <= tick_counter + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      alpha_first <= res[0];
      beta_first <= res[1];
      alpha_third <= res[2];
      beta_third <= res[3];
      switch_bits <= bits_r;
      period_start <= start_r;
    end
  end

endmodule

// ===== hdl/five_phase_space_vector_pwm_top.sv =====
// Top level of the five-phase space vector PWM.
// Joins fpsv_ctrl and fpsv_dp; depends on fpsv_pkg.

// One input word is one carrier tick and gives one result word. A tick at
// period start (tick counter zero) runs the shared ratio divider and CORDIC,
// two bit-serial on-time divisions and the steps of the single shared
// multiplier. Every other tick runs only the four output products on that
// multiplier. One tick is worked on at a time; the next word is taken while
// the previous result waits in the output register.
module five_phase_space_vector_pwm_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        amplitude,
  input  logic [15:0]        angle,
  input  logic [15:0]        dc_voltage,
  input  logic               phase_a_current_negative,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [17:0] alpha_first,
  output logic signed [17:0] beta_first,
  output logic signed [17:0] alpha_third,
  output logic signed [17:0] beta_third,
  output logic [4:0]         switch_bits,
  output logic               period_start
);
  import fpsv_pkg::*;

  cmd_t    cmd;
  status_t status;

  fpsv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  fpsv_dp u_dp (
    .clk                      (clk),
    .rst                      (rst),
    .cfg_we                   (cfg_we),
    .cfg_index                (cfg_index),
    .cfg_data                 (cfg_data),
    .amplitude                (amplitude),
    .angle                    (angle),
    .dc_voltage               (dc_voltage),
    .phase_a_current_negative (phase_a_current_negative),
    .cmd                      (cmd),
    .status                   (status),
    .alpha_first              (alpha_first),
    .beta_first               (beta_first),
    .alpha_third              (alpha_third),
    .beta_third               (beta_third),
    .switch_bits              (switch_bits),
    .period_start             (period_start)
  );

endmodule
